[src/cfp_pkg.sv]
package cfp_pkg;

    // Default width of the packet age counter.
    localparam int AGE_BITS_DEF = 16;

    // Entries in the queue between the frame parser and the result stage.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int PAYLOAD_N = 5;
    localparam int PAYLOAD_W = BYTE_W * PAYLOAD_N;
    localparam int TOUT_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER_FIRST     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER_SECOND    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CALIBRATE_CODE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAILSAFE_TIMEOUT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TELEMETRY_DELAY  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [TOUT_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [BYTE_W-1:0] TELEM_RST   = 8'd30;

    // Input item kinds carried in tuser.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Frame positions.
    localparam logic [2:0] POS_HEADER1  = 3'd0;
    localparam logic [2:0] POS_HEADER2  = 3'd1;
    localparam logic [2:0] POS_PAYLOAD0 = 3'd2;
    localparam logic [2:0] POS_CHECKSUM = 3'd7;

    typedef enum logic [1:0] {
        EV_COMMAND   = 2'd0,
        EV_CALIBRATE = 2'd1,
        EV_TELEMETRY = 2'd2,
        EV_FAILSAFE  = 2'd3
    } cfp_event_t;

    // All results caused by one input item.
    typedef struct packed {
        logic                 two_res;
        cfp_event_t           ev0;
        cfp_event_t           ev1;
        logic [PAYLOAD_W-1:0] payload;
    } cfp_bundle_t;

endpackage

[src/cfp_front.sv]
module cfp_front
    import cfp_pkg::*;
#(
    parameter int AGE_BITS = AGE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_accept,
    input  logic                  in_action,
    input  logic [BYTE_W-1:0]     in_byte,
    output logic                  push,
    output cfp_bundle_t           push_data
);

    localparam int CMP_W = (AGE_BITS > TOUT_W) ? AGE_BITS : TOUT_W;

    logic [BYTE_W-1:0]   hdr1_reg, hdr2_reg, cal_reg, delay_reg;
    logic [TOUT_W-1:0]   timeout_reg;
    logic [2:0]          pos_reg, pos_next;
    logic [BYTE_W-1:0]   pl_reg [PAYLOAD_N];
    logic [AGE_BITS-1:0] age_reg, age_next, age_inc;
    logic [BYTE_W-1:0]   cd_reg, cd_next, cd_dec;
    logic                pend_reg, pend_next;
    logic                fs_reg, fs_next;
    logic                pl_we;
    logic [2:0]          pl_idx;
    logic [BYTE_W-1:0]   sum;
    logic                frame_ok;
    logic                telem_fire, fs_fire;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr1_reg    <= '0;
            hdr2_reg    <= '0;
            cal_reg     <= '0;
            timeout_reg <= TIMEOUT_RST;
            delay_reg   <= TELEM_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_HEADER_FIRST:     hdr1_reg    <= cfg_wdata[BYTE_W-1:0];
                CFG_HEADER_SECOND:    hdr2_reg    <= cfg_wdata[BYTE_W-1:0];
                CFG_CALIBRATE_CODE:   cal_reg     <= cfg_wdata[BYTE_W-1:0];
                CFG_FAILSAFE_TIMEOUT: timeout_reg <= cfg_wdata[TOUT_W-1:0];
                CFG_TELEMETRY_DELAY:  delay_reg   <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Checksum over the stored payload and tick arithmetic.
    always_comb begin
        sum = '0;
        for (int i = 0; i < PAYLOAD_N; i++) begin
            sum = sum ^ pl_reg[i];
        end
        age_inc    = (age_reg == '1) ? age_reg : age_reg + 1'b1;
        cd_dec     = (cd_reg != '0) ? cd_reg - 1'b1 : cd_reg;
        frame_ok   = (sum == in_byte);
        telem_fire = pend_reg && (cd_dec == '0);
        fs_fire    = (CMP_W'(age_inc) > CMP_W'(timeout_reg)) && !fs_reg;
        pl_idx     = pos_reg - POS_PAYLOAD0;
    end

    // Next state and the bundle of results for the accepted item.
    always_comb begin
        pos_next  = pos_reg;
        age_next  = age_reg;
        cd_next   = cd_reg;
        pend_next = pend_reg;
        fs_next   = fs_reg;
        pl_we     = 1'b0;
        push      = 1'b0;
        push_data = '{two_res: 1'b0, ev0: EV_COMMAND, ev1: EV_COMMAND, payload: '0};
        if (in_accept) begin
            if (in_action == ACT_TICK) begin
                age_next = age_inc;
                if (pend_reg) begin
                    cd_next = cd_dec;
                end
                if (telem_fire) begin
                    pend_next = 1'b0;
                end
                if (fs_fire) begin
                    fs_next = 1'b1;
                end
                push              = telem_fire || fs_fire;
                push_data.two_res = telem_fire && fs_fire;
                push_data.ev0     = telem_fire ? EV_TELEMETRY : EV_FAILSAFE;
                push_data.ev1     = EV_FAILSAFE;
            end else begin
                unique case (pos_reg)
                    POS_HEADER1: begin
                        if (in_byte == hdr1_reg) begin
                            pos_next = POS_HEADER2;
                        end
                    end
                    POS_HEADER2: begin
                        pos_next = (in_byte == hdr2_reg) ? POS_PAYLOAD0 : POS_HEADER1;
                    end
                    POS_CHECKSUM: begin
                        pos_next = POS_HEADER1;
                        if (frame_ok) begin
                            age_next          = '0;
                            fs_next           = 1'b0;
                            push              = 1'b1;
                            push_data.payload = {pl_reg[4], pl_reg[3], pl_reg[2],
                                                 pl_reg[1], pl_reg[0]};
                            if (pl_reg[4] == cal_reg) begin
                                push_data.ev0 = EV_CALIBRATE;
                            end else begin
                                push_data.ev0 = EV_COMMAND;
                                cd_next       = delay_reg;
                                pend_next     = 1'b1;
                            end
                        end
                    end
                    default: begin
                        pl_we    = 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end
                endcase
            end
        end
    end

    // Parser and timer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_HEADER1;
            age_reg  <= '0;
            cd_reg   <= '0;
            pend_reg <= 1'b0;
            fs_reg   <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            age_reg  <= age_next;
            cd_reg   <= cd_next;
            pend_reg <= pend_next;
            fs_reg   <= fs_next;
        end
    end

    // Payload byte store.
    always_ff @(posedge aclk) begin
        if (pl_we) begin
            pl_reg[pl_idx] <= in_byte;
        end
    end

    // A frame never produces two results.
    a_frame_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && in_action == ACT_BYTE) |-> !push_data.two_res)
        else $error("frame produced two results");

    // A failsafe result always leaves the failsafe flag set.
    a_fs_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && in_action == ACT_TICK &&
         (push_data.ev0 == EV_FAILSAFE || push_data.two_res)) |=> fs_reg)
        else $error("failsafe result without failsafe flag");

endmodule

[src/cfp_queue.sv]
module cfp_queue
    import cfp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  cfp_bundle_t push_data,
    input  logic        pop,
    output cfp_bundle_t head,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfp_bundle_t        mem [DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("queue underflow");

endmodule

[src/cfp_back.sv]
module cfp_back
    import cfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfp_bundle_t          head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic       sub_reg, sub_next;
    logic       out_accept;
    cfp_event_t ev;

    // Pick the first or second result of the head bundle.
    always_comb begin
        ev         = sub_reg ? head.ev1 : head.ev0;
        m_tvalid   = !empty;
        m_tlast    = sub_reg || !head.two_res;
        m_tdata    = M_TDATA_W'({head.payload, ev});
        out_accept = m_tvalid && m_tready;
        pop        = out_accept && m_tlast;
        sub_next   = sub_reg;
        if (out_accept) begin
            sub_next = !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg <= 1'b0;
        end else begin
            sub_reg <= sub_next;
        end
    end

    // The second result of a bundle is only reached in a two-result bundle.
    a_sub_two: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> (head.two_res && !empty))
        else $error("second result selected without two results");

endmodule

[src/command_frame_parser_failsafe.sv]
// Channel   Direction  Ports                    Contents
// s_        in         s_tvalid/s_tready        tuser: action; tdata: rx_byte
// m_        out        m_tvalid/m_tready        tdata: event_res, pitch, roll, yaw,
//                                               thrust, mode; tlast: last
// cfg_      in         cfg_we/cfg_addr/wdata    register writes, no read-back
//
// An input transaction is taken every cycle while the result queue has room.
// Its results are registered in the result queue and leave on the master side, one per cycle
// while m_tready is high; a tick that causes both telemetry and failsafe sends two results.
// The sustained rate is one item per cycle, limited by the output port when
// items produce two results. Reset needs no clearing pass.
// Master-side stalls fill the queue of QUEUE_DEPTH bundles, then s_tready drops.
module command_frame_parser_failsafe
    import cfp_pkg::*;
#(
    parameter int AGE_BITS    = AGE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic                  s_tuser,   // [0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [1:0] event_res, [9:2] pitch,
                                             // [17:10] roll, [25:18] yaw,
                                             // [33:26] thrust, [41:34] mode
    output logic                  m_tlast
);

    logic        in_accept;
    logic        push, pop, full, empty;
    cfp_bundle_t push_data, head;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    cfp_front #(
        .AGE_BITS (AGE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_action (s_tuser),
        .in_byte   (s_tdata[BYTE_W-1:0]),
        .push      (push),
        .push_data (push_data)
    );

    cfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    cfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[test/cfp_event_monitor.sv]
module cfp_event_monitor
    import cfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic                  s_tuser,   // [0] action
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [1:0] event_res, [9:2] pitch,
                                             // [17:10] roll, [25:18] yaw,
                                             // [33:26] thrust, [41:34] mode
    input  logic                  m_tlast,
    output int                    mismatch_count,
    output int                    events_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AGE_W = AGE_BITS_DEF;
    localparam int EV_W  = $bits(cfp_event_t);

    // One event the block is expected to send.
    typedef struct packed {
        cfp_event_t                       ev;
        logic [PAYLOAD_N-1:0][BYTE_W-1:0] payload;
        logic                             last;
    } frame_event_t;

    // Register copies.
    logic [BYTE_W-1:0] hdr_first;
    logic [BYTE_W-1:0] hdr_second;
    logic [BYTE_W-1:0] cal_code;
    logic [TOUT_W-1:0] fs_timeout;
    logic [BYTE_W-1:0] tel_delay;

    // Parser and link state.
    logic [2:0]                       frame_pos;
    logic [PAYLOAD_N-1:0][BYTE_W-1:0] frame_bytes;
    logic [AGE_W-1:0]                 pkt_age;
    logic [BYTE_W-1:0]                tel_count;
    logic                             tel_armed;
    logic                             fs_latched;

    frame_event_t expected_events [$];
    int           errors = 0;
    string        payload_names [PAYLOAD_N] = '{"pitch", "roll", "yaw", "thrust", "mode"};

    task automatic reset_predictor();
        hdr_first   = '0;
        hdr_second  = '0;
        cal_code    = '0;
        fs_timeout  = TIMEOUT_RST;
        tel_delay   = TELEM_RST;
        frame_pos   = POS_HEADER1;
        frame_bytes = '0;
        pkt_age     = '0;
        tel_count   = '0;
        tel_armed   = 1'b0;
        fs_latched  = 1'b0;
    endtask

    // A received byte advances the frame hunt; a good checksum yields one event.
    task automatic take_rx_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] sum;
        frame_event_t      ev_item;
        case (frame_pos)
            POS_HEADER1: begin
                if (b == hdr_first) frame_pos = POS_HEADER2;
            end
            POS_HEADER2: begin
                // A wrong second byte drops both header bytes, no retry.
                frame_pos = (b == hdr_second) ? POS_PAYLOAD0 : POS_HEADER1;
            end
            POS_CHECKSUM: begin
                frame_pos = POS_HEADER1;
                sum = '0;
                for (int i = 0; i < PAYLOAD_N; i++) sum ^= frame_bytes[i];
                if (sum == b) begin
                    pkt_age    = '0;
                    fs_latched = 1'b0;
                    ev_item.payload = frame_bytes;
                    ev_item.last    = 1'b1;
                    if (frame_bytes[PAYLOAD_N-1] == cal_code) begin
                        ev_item.ev = EV_CALIBRATE;
                    end else begin
                        ev_item.ev = EV_COMMAND;
                        tel_count  = tel_delay;
                        tel_armed  = 1'b1;
                    end
                    expected_events.push_back(ev_item);
                end
            end
            default: begin
                frame_bytes[frame_pos - POS_PAYLOAD0] = b;
                frame_pos = frame_pos + 3'd1;
            end
        endcase
    endtask

    // A tick ages the link; telemetry comes before failsafe when both fire.
    task automatic take_tick();
        logic tel_fire;
        logic fs_fire;
        if (pkt_age != '1) pkt_age = pkt_age + 1'b1;
        tel_fire = 1'b0;
        if (tel_armed) begin
            if (tel_count != '0) tel_count = tel_count - 1'b1;
            if (tel_count == '0) begin
                tel_armed = 1'b0;
                tel_fire  = 1'b1;
            end
        end
        fs_fire = (pkt_age > fs_timeout) && !fs_latched;
        if (fs_fire) fs_latched = 1'b1;
        if (tel_fire) expected_events.push_back('{ev: EV_TELEMETRY, payload: '0, last: !fs_fire});
        if (fs_fire) expected_events.push_back('{ev: EV_FAILSAFE, payload: '0, last: 1'b1});
    endtask

    function automatic void compare_field(input string label, input logic [BYTE_W-1:0] want,
                                          input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
            errors++;
        end
    endfunction

    // Register writes first, then the result check, then the prediction for
    // the input transaction of this edge.
    always @(posedge aclk) begin
        frame_event_t want;
        if (!aresetn) begin
            reset_predictor();
            expected_events.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_HEADER_FIRST:     hdr_first  = cfg_wdata[BYTE_W-1:0];
                    CFG_HEADER_SECOND:    hdr_second = cfg_wdata[BYTE_W-1:0];
                    CFG_CALIBRATE_CODE:   cal_code   = cfg_wdata[BYTE_W-1:0];
                    CFG_FAILSAFE_TIMEOUT: fs_timeout = cfg_wdata[TOUT_W-1:0];
                    CFG_TELEMETRY_DELAY:  tel_delay  = cfg_wdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, %s %h tlast %b",
                             $time, "actual tdata", m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    compare_field("event_res", BYTE_W'(want.ev),
                                  BYTE_W'(m_tdata[EV_W-1:0]));
                    for (int i = 0; i < PAYLOAD_N; i++) begin
                        compare_field(payload_names[i], want.payload[i],
                                      m_tdata[EV_W + BYTE_W*i +: BYTE_W]);
                    end
                    compare_field("tdata padding", '0,
                                  BYTE_W'(m_tdata[M_TDATA_W-1:EV_W+PAYLOAD_W]));
                    compare_field("tlast", BYTE_W'(want.last), BYTE_W'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == ACT_TICK) take_tick();
                else take_rx_byte(s_tdata);
            end
        end
        mismatch_count     <= errors;
        events_outstanding <= expected_events.size();
    end

endmodule

[test/tb_top.sv]
module tb_top
    import cfp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF      = 4;
    localparam int  RESET_CYCLES  = 5;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  PHASES        = 8;
    localparam int  PHASE_ITEMS   = 85;
    localparam int  FRAME_LEN     = PAYLOAD_N + 3;
    localparam int  MAX_WAIT      = 10;
    localparam real LIMIT_NS      = 5.0e6;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic                  s_tuser   = ACT_BYTE;   // [0] action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // [1:0] event_res, [9:2] pitch, [17:10] roll,
                                      // [25:18] yaw, [33:26] thrust, [41:34] mode
    logic                  m_tlast;

    int mismatch_count;
    int events_outstanding;

    // Stimulus-side copies of the registers that shape frames.
    logic [BYTE_W-1:0] cur_hf = '0;
    logic [BYTE_W-1:0] cur_hs = '0;
    logic [BYTE_W-1:0] cur_cc = '0;

    bit calm_s   = 1'b0;
    bit calm_m   = 1'b0;
    int items_sent = 0;

    command_frame_parser_failsafe i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    cfp_event_monitor i_monitor (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tlast            (m_tlast),
        .mismatch_count     (mismatch_count),
        .events_outstanding (events_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #LIMIT_NS;
        $display("Mismatches found");
        $finish;
    end

    // Wait before each transaction; now and then switch to a run without gaps.
    function automatic int pick_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0) calm = !calm;
        if (calm) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic send_item(input logic act, input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_wait(calm_s);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(ACT_TICK, BYTE_W'($urandom_range(0, 255)));
    endtask

    // Header, payload and checksum; ticks may be slipped in between bytes.
    task automatic send_frame(input logic [BYTE_W-1:0] pl [PAYLOAD_N], input bit bad_sum,
                              input bit ticks_inside);
        logic [BYTE_W-1:0] sum;
        sum = '0;
        send_item(ACT_BYTE, cur_hf);
        send_item(ACT_BYTE, cur_hs);
        foreach (pl[i]) begin
            if (ticks_inside && $urandom_range(0, 2) == 0) send_item(ACT_TICK, pl[i]);
            send_item(ACT_BYTE, pl[i]);
            sum ^= pl[i];
        end
        if (bad_sum) sum ^= BYTE_W'($urandom_range(1, 255));
        send_item(ACT_BYTE, sum);
    endtask

    // Bytes that never match the first header bring the parser back to hunting.
    task automatic resync();
        repeat (FRAME_LEN) send_item(ACT_BYTE, ~cur_hf);
    endtask

    // Stop sending and let every pending transaction through the block.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (events_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [BYTE_W-1:0] hf, hs, cc,
                                input logic [TOUT_W-1:0] tmo, input logic [BYTE_W-1:0] dly);
        logic [CFG_ADDR_W-1:0] addr [5];
        logic [CFG_DATA_W-1:0] data [5];
        addr = '{CFG_HEADER_FIRST, CFG_HEADER_SECOND, CFG_CALIBRATE_CODE,
                 CFG_FAILSAFE_TIMEOUT, CFG_TELEMETRY_DELAY};
        data = '{CFG_DATA_W'(hf), CFG_DATA_W'(hs), CFG_DATA_W'(cc),
                 CFG_DATA_W'(tmo), CFG_DATA_W'(dly)};
        cur_hf = hf;
        cur_hs = hs;
        cur_cc = cc;
        foreach (addr[i]) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addr[i];
            cfg_wdata <= data[i];
            @(posedge aclk);
        end
        // An index past the last register must leave every register alone.
        cfg_addr  <= CFG_ADDR_W'($urandom_range(CFG_TELEMETRY_DELAY + 1, (1 << CFG_ADDR_W) - 1));
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, plus ticks and broken input.
    task automatic send_random_step();
        logic [BYTE_W-1:0] pl [PAYLOAD_N];
        logic [BYTE_W-1:0] bad;
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        foreach (pl[i]) pl[i] = BYTE_W'($urandom_range(0, 255));
        if (pick < 55) begin
            if ($urandom_range(0, 3) == 0) pl[PAYLOAD_N-1] = cur_cc;
            send_frame(pl, $urandom_range(0, 6) == 0, $urandom_range(0, 4) == 0);
        end else if (pick < 80) begin
            send_ticks($urandom_range(1, 6));
        end else if (pick < 85) begin
            send_ticks($urandom_range(1, 40));
        end else if (pick < 90) begin
            send_item(ACT_BYTE, (pl[0] == cur_hf) ? ~cur_hf : pl[0]);
        end else if (pick < 94) begin
            // The wrong second byte is sometimes the first header value itself.
            bad = (pl[0] == cur_hs) ? ~cur_hs : pl[0];
            if ($urandom_range(0, 1) == 1 && cur_hf != cur_hs) bad = cur_hf;
            send_item(ACT_BYTE, cur_hf);
            send_item(ACT_BYTE, bad);
        end else if (pick < 97) begin
            send_item(ACT_BYTE, cur_hf);
            send_item(ACT_BYTE, cur_hs);
            n = $urandom_range(0, PAYLOAD_N - 1);
            for (int i = 0; i < n; i++) send_item(ACT_BYTE, pl[i]);
            resync();
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) send_item(ACT_BYTE, pl[i]);
            resync();
        end
    endtask

    // Result side: a random stall before each transaction.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = pick_wait(calm_m);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic [BYTE_W-1:0] pl [PAYLOAD_N];
        int phase_end;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset register values: zero headers and a zero calibrate code.
        send_frame('{8'h01, 8'h02, 8'h03, 8'h04, 8'h00}, 1'b0, 1'b0);
        drain();

        // Zero timeout and a one tick telemetry delay.
        write_config(8'hFF, 8'h00, 8'hFF, 16'd0, 8'd1);
        send_item(ACT_BYTE, 8'h12);
        // A second header byte that equals the first header is not retried.
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, 8'hFF);
        send_frame('{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b0, 1'b0);
        send_item(ACT_TICK, 8'h00);
        send_frame('{8'h01, 8'h02, 8'h04, 8'h08, 8'h10}, 1'b0, 1'b0);
        // Telemetry and failsafe from the same tick.
        send_item(ACT_TICK, 8'hFF);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_config(8'h00, 8'hFF, 8'h00, 16'd0, 8'd0);
                1: write_config(8'hFF, 8'h00, 8'hFF, 16'hFFFF, 8'd255);
                2: begin
                    pl[0] = BYTE_W'($urandom_range(0, 255));
                    write_config(pl[0], pl[0], BYTE_W'($urandom_range(0, 255)),
                                 TOUT_W'($urandom_range(0, 30)), 8'd1);
                end
                default: write_config(BYTE_W'($urandom_range(0, 255)),
                                      BYTE_W'($urandom_range(0, 255)),
                                      BYTE_W'($urandom_range(0, 255)),
                                      TOUT_W'($urandom_range(0, 30)),
                                      BYTE_W'($urandom_range(0, 40)));
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) send_random_step();
            drain();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
